// ===== hdl/fat_dir_entry_parser_core_defines.svh =====
// Assertion macros shared by the directory entry parser checker.
`ifndef FAT_DIR_ENTRY_PARSER_CORE_DEFINES_SVH
`define FAT_DIR_ENTRY_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the given clock, off while dis is high.
`define FDEP_ASSERT_SAME(lbl, clk, dis, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the given clock, off while dis is high.
`define FDEP_ASSERT_NEXT(lbl, clk, dis, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/fdep_pkg.sv =====
// Types, codes and helpers of the FAT directory entry parser.
`timescale 1ns / 1ps

package fdep_pkg;

    // Record layout
    localparam logic [4:0] C_POS_BASE_LAST = 5'd7;
    localparam logic [4:0] C_POS_EXT_FIRST = 5'd8;
    localparam logic [4:0] C_POS_EXT_LAST  = 5'd10;
    localparam logic [4:0] C_POS_ATTR      = 5'd11;
    localparam logic [4:0] C_POS_CLU_HI_LO = 5'd20;
    localparam logic [4:0] C_POS_CLU_HI_HI = 5'd21;
    localparam logic [4:0] C_POS_CLU_LO_LO = 5'd26;
    localparam logic [4:0] C_POS_CLU_LO_HI = 5'd27;
    localparam logic [4:0] C_POS_SIZE_FIRST = 5'd28;
    localparam logic [4:0] C_POS_SIZE_LAST = 5'd30;
    localparam logic [4:0] C_POS_REC_LAST  = 5'd31;

    // Byte codes
    localparam logic [7:0] C_MARK_FREE      = 8'h00;
    localparam logic [7:0] C_MARK_DELETED   = 8'hE5;
    localparam logic [7:0] C_CHAR_DOT       = 8'h2E;
    localparam logic [7:0] C_CHAR_SPACE     = 8'h20;
    localparam logic [7:0] C_CHAR_UPPER_A   = 8'h41;
    localparam logic [7:0] C_CHAR_UPPER_Z   = 8'h5A;
    localparam logic [7:0] C_ATTR_LONG_NAME = 8'h0F;
    localparam int         C_ATTR_DIR_BIT   = 4;

    localparam logic [3:0] C_BASE_MAX = 4'd8;
    localparam logic [1:0] C_EXT_MAX  = 2'd3;

    // One parsed record
    typedef struct packed {
        logic [63:0] base_name;
        logic [3:0]  base_length;
        logic [23:0] ext_name;
        logic [1:0]  ext_length;
        logic        is_directory;
        logic [31:0] file_bytes;
        logic [31:0] start_cluster;
    } t_result;

    // Fold uppercase ASCII letters to lowercase, pass everything else
    function automatic logic [7:0] f_to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= C_CHAR_UPPER_A && c <= C_CHAR_UPPER_Z) begin
            r = c | 8'h20;
        end
        return r;
    endfunction

endpackage

// ===== hdl/fat_dir_entry_parser_core.sv =====
// Top level of the FAT 8.3 directory entry parser.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake           Payload
//  input     in         i_valid / o_stall   i_dir_byte
//  result    out        o_valid / i_stall   o_base_name .. o_start_cluster
//
//  One byte is taken per cycle while o_stall is low. A byte is held in the
//  input register, then updates the record state; byte 31 of a kept record
//  loads the result register, which then raises o_valid with the result.
//  Reset (synchronous, active low) aligns the record counter to byte 0 and
//  empties both registers. The input stalls only when a record's last byte
//  would produce a result while the previous result is still held.

module fat_dir_entry_parser_core
    import fdep_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_dir_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_base_name,
    output logic [3:0]  o_base_length,
    output logic [23:0] o_ext_name,
    output logic [1:0]  o_ext_length,
    output logic        o_is_directory,
    output logic [31:0] o_file_bytes,
    output logic [31:0] o_start_cluster
);

    // Input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;

    // Record state
    logic [4:0]  r_pos;
    logic [63:0] r_base_chars, n_base_chars;
    logic [3:0]  r_base_cnt,   n_base_cnt;
    logic        r_base_stop,  n_base_stop;
    logic [23:0] r_ext_chars,  n_ext_chars;
    logic [1:0]  r_ext_cnt,    n_ext_cnt;
    logic        r_ext_stop,   n_ext_stop;
    logic        r_skip,       n_skip;
    logic        r_is_dir,     n_is_dir;
    logic [15:0] r_clu_hi,     n_clu_hi;
    logic [15:0] r_clu_lo,     n_clu_lo;
    logic [23:0] r_size_lo,    n_size_lo;

    // Result register
    logic        r_out_valid;
    t_result     r_out, n_out;

    logic        w_emit;
    logic        w_block;
    logic        w_step;
    logic        w_first;
    logic [7:0]  w_char;

    // Hold everything when a result meets a held, stalled result
    assign w_emit  = (r_pos == C_POS_REC_LAST) && !r_skip;
    assign w_block = r_in_valid && w_emit && r_out_valid && i_stall;
    assign w_step  = r_in_valid && !w_block;
    assign w_first = (r_pos == 5'd0);
    assign w_char  = f_to_lower(r_in_byte);
    assign o_stall = w_block;

    // Advance the record state by one byte
    always_comb begin
        n_base_chars = w_first ? 64'd0 : r_base_chars;
        n_base_cnt   = w_first ? 4'd0  : r_base_cnt;
        n_base_stop  = w_first ? 1'b0  : r_base_stop;
        n_ext_chars  = w_first ? 24'd0 : r_ext_chars;
        n_ext_cnt    = w_first ? 2'd0  : r_ext_cnt;
        n_ext_stop   = w_first ? 1'b0  : r_ext_stop;
        n_is_dir     = w_first ? 1'b0  : r_is_dir;
        n_clu_hi     = w_first ? 16'd0 : r_clu_hi;
        n_clu_lo     = w_first ? 16'd0 : r_clu_lo;
        n_size_lo    = w_first ? 24'd0 : r_size_lo;
        n_skip       = w_first ? (r_in_byte == C_MARK_FREE || r_in_byte == C_MARK_DELETED ||
                                  r_in_byte == C_CHAR_DOT)
                               : r_skip;

        if (r_pos <= C_POS_BASE_LAST) begin
            if (!n_base_stop) begin
                if (r_in_byte == C_CHAR_SPACE) begin
                    n_base_stop = 1'b1;
                end else if (n_base_cnt < C_BASE_MAX) begin
                    n_base_chars[{n_base_cnt[2:0], 3'b000} +: 8] = w_char;
                    n_base_cnt = n_base_cnt + 4'd1;
                end
            end
        end else if (r_pos inside {[C_POS_EXT_FIRST:C_POS_EXT_LAST]}) begin
            if (!n_ext_stop) begin
                if (r_in_byte == C_CHAR_SPACE) begin
                    n_ext_stop = 1'b1;
                end else if (n_ext_cnt < C_EXT_MAX) begin
                    n_ext_chars[{n_ext_cnt, 3'b000} +: 8] = w_char;
                    n_ext_cnt = n_ext_cnt + 2'd1;
                end
            end
        end else if (r_pos == C_POS_ATTR) begin
            n_is_dir = r_in_byte[C_ATTR_DIR_BIT];
            if (r_in_byte == C_ATTR_LONG_NAME) begin
                n_skip = 1'b1;
            end
        end else if (r_pos == C_POS_CLU_HI_LO) begin
            n_clu_hi[7:0] = r_in_byte;
        end else if (r_pos == C_POS_CLU_HI_HI) begin
            n_clu_hi[15:8] = r_in_byte;
        end else if (r_pos == C_POS_CLU_LO_LO) begin
            n_clu_lo[7:0] = r_in_byte;
        end else if (r_pos == C_POS_CLU_LO_HI) begin
            n_clu_lo[15:8] = r_in_byte;
        end else if (r_pos inside {[C_POS_SIZE_FIRST:C_POS_SIZE_LAST]}) begin
            n_size_lo[{r_pos[1:0], 3'b000} +: 8] = r_in_byte;
        end
    end

    // Assemble the result from the finished record
    always_comb begin
        n_out.base_name     = r_base_chars;
        n_out.base_length   = r_base_cnt;
        n_out.ext_name      = r_ext_chars;
        n_out.ext_length    = r_ext_cnt;
        n_out.is_directory  = r_is_dir;
        n_out.file_bytes    = {r_in_byte, r_size_lo};
        n_out.start_cluster = {r_clu_hi, r_clu_lo};
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_pos       <= 5'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (!w_block) begin
                r_in_valid <= i_valid;
            end
            if (w_step) begin
                r_pos <= r_pos + 5'd1;
            end
            if (w_step && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_valid && !w_block) begin
            r_in_byte <= i_dir_byte;
        end
        if (w_step) begin
            r_base_chars <= n_base_chars;
            r_base_cnt   <= n_base_cnt;
            r_base_stop  <= n_base_stop;
            r_ext_chars  <= n_ext_chars;
            r_ext_cnt    <= n_ext_cnt;
            r_ext_stop   <= n_ext_stop;
            r_skip       <= n_skip;
            r_is_dir     <= n_is_dir;
            r_clu_hi     <= n_clu_hi;
            r_clu_lo     <= n_clu_lo;
            r_size_lo    <= n_size_lo;
        end
        if (w_step && w_emit) begin
            r_out <= n_out;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_base_name     = r_out.base_name;
    assign o_base_length   = r_out.base_length;
    assign o_ext_name      = r_out.ext_name;
    assign o_ext_length    = r_out.ext_length;
    assign o_is_directory  = r_out.is_directory;
    assign o_file_bytes    = r_out.file_bytes;
    assign o_start_cluster = r_out.start_cluster;

endmodule

// ===== hdl/fdep_checker.sv =====
// Port-level checks of the directory entry parser and their binding.
`timescale 1ns / 1ps
`include "fat_dir_entry_parser_core_defines.svh"

module fdep_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [7:0]  i_dir_byte,
    input logic        o_valid,
    input logic        i_stall,
    input logic [63:0] o_base_name,
    input logic [3:0]  o_base_length,
    input logic [23:0] o_ext_name,
    input logic [1:0]  o_ext_length,
    input logic        o_is_directory,
    input logic [31:0] o_file_bytes,
    input logic [31:0] o_start_cluster
);

    // Reset empties the result register
    `FDEP_ASSERT_NEXT(a_reset_empty, i_clk, 1'b0, !i_rst_n, !o_valid, "result valid after reset")

    // Input stalls only behind a held, stalled result
    `FDEP_ASSERT_SAME(a_stall_cause, i_clk, !i_rst_n, o_stall, o_valid && i_stall, "input stall without a held result")

    // Base name is at most eight characters, and empty means all zero
    `FDEP_ASSERT_SAME(a_base_len, i_clk, !i_rst_n, o_valid, o_base_length <= 4'd8 && (o_base_length != 4'd0 || o_base_name == 64'd0), "bad base name length")

    // No extension means no extension bytes
    `FDEP_ASSERT_SAME(a_ext_empty, i_clk, !i_rst_n, o_valid && o_ext_length == 2'd0, o_ext_name == 24'd0, "extension bytes without length")

    // A stalled result holds
    `FDEP_ASSERT_NEXT(a_out_hold, i_clk, !i_rst_n, o_valid && i_stall, o_valid && $stable(o_base_name) && $stable(o_file_bytes) && $stable(o_start_cluster), "stalled result changed")

endmodule

bind fat_dir_entry_parser_core fdep_checker u_fdep_checker (.*);

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the FAT 8.3 directory entry parser core.
`timescale 1ns / 1ps

module tb;
    import fdep_pkg::*;

    localparam int NUM_RANDOM_RECORDS = 36;
    localparam int WATCHDOG_LIMIT     = 3000;
    localparam int LONG_HOLD_CYCLES   = 300;
    localparam int MAX_REPORTS        = 10;
    localparam int DRAIN_CYCLES       = 16;

    localparam logic [7:0] CH_LOWER_A     = "a";
    localparam logic [7:0] CH_LOWER_Z     = "z";
    localparam logic [7:0] CH_DIGIT_0     = "0";
    localparam logic [7:0] CH_DIGIT_9     = "9";
    localparam logic [7:0] ATTR_DIRECTORY = 8'h10;
    localparam logic [7:0] ATTR_ARCHIVE   = 8'h20;
    localparam logic [7:0] ATTR_NONE      = 8'h00;

    // How the expectation of a directed record is formed
    typedef enum logic [1:0] {ROW_PREDICT, ROW_TYPED, ROW_NONE} t_row_kind;

    typedef struct {
        logic [255:0] raw;
        t_row_kind    kind;
        t_result      entry;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n    = 1'b0;
    logic        i_valid    = 1'b0;
    logic [7:0]  i_dir_byte = 8'h00;
    logic        i_stall    = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [63:0] o_base_name;
    logic [3:0]  o_base_length;
    logic [23:0] o_ext_name;
    logic [1:0]  o_ext_length;
    logic        o_is_directory;
    logic [31:0] o_file_bytes;
    logic [31:0] o_start_cluster;

    fat_dir_entry_parser_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_dir_byte      (i_dir_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_base_name     (o_base_name),
        .o_base_length   (o_base_length),
        .o_ext_name      (o_ext_name),
        .o_ext_length    (o_ext_length),
        .o_is_directory  (o_is_directory),
        .o_file_bytes    (o_file_bytes),
        .o_start_cluster (o_start_cluster)
    );

    // Parser state tracked alongside the block
    logic [4:0]  rec_pos    = '0;
    logic [63:0] base_acc   = '0;
    logic [3:0]  base_len   = '0;
    bit          base_done  = 1'b0;
    logic [23:0] ext_acc    = '0;
    logic [1:0]  ext_len    = '0;
    bit          ext_done   = 1'b0;
    bit          drop_rec   = 1'b0;
    logic [7:0]  attr_byte  = '0;
    logic [15:0] clu_hi     = '0;
    logic [15:0] clu_lo     = '0;
    logic [23:0] size_lo    = '0;

    t_result   pending_entries[$];
    t_dir_row  dir_rows[$];
    t_row_kind cur_kind  = ROW_PREDICT;
    t_result   cur_typed = '0;
    bit        long_hold_req = 1'b0;

    int mismatch_count  = 0;
    int entries_checked = 0;
    int records_sent    = 0;
    int bytes_sent      = 0;
    int records_skipped = 0;
    int idle_cycles     = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (c >= C_CHAR_UPPER_A && c <= C_CHAR_UPPER_Z) begin
            return c + 8'd32;
        end
        return c;
    endfunction

    // Advance the tracked parser by one byte; report the entry a record yields
    task automatic parse_dir_byte(input logic [7:0] b, output bit got, output t_result entry);
        logic [7:0] lc;
        lc = fold_case(b);
        got = 1'b0;
        entry = '0;
        if (rec_pos == 5'd0) begin
            base_acc  = '0;
            base_len  = '0;
            base_done = 1'b0;
            ext_acc   = '0;
            ext_len   = '0;
            ext_done  = 1'b0;
            attr_byte = '0;
            clu_hi    = '0;
            clu_lo    = '0;
            size_lo   = '0;
            drop_rec  = (b == C_MARK_FREE) || (b == C_MARK_DELETED) || (b == C_CHAR_DOT);
        end
        if (rec_pos <= C_POS_BASE_LAST) begin
            if (!base_done) begin
                if (b == C_CHAR_SPACE) begin
                    base_done = 1'b1;
                end else if (base_len < C_BASE_MAX) begin
                    base_acc[8*base_len +: 8] = lc;
                    base_len = base_len + 4'd1;
                end
            end
        end else if (rec_pos <= C_POS_EXT_LAST) begin
            if (!ext_done) begin
                if (b == C_CHAR_SPACE) begin
                    ext_done = 1'b1;
                end else if (ext_len < C_EXT_MAX) begin
                    ext_acc[8*ext_len +: 8] = lc;
                    ext_len = ext_len + 2'd1;
                end
            end
        end else if (rec_pos == C_POS_ATTR) begin
            attr_byte = b;
            if (b == C_ATTR_LONG_NAME) begin
                drop_rec = 1'b1;
            end
        end else if (rec_pos == C_POS_CLU_HI_LO) begin
            clu_hi[7:0] = b;
        end else if (rec_pos == C_POS_CLU_HI_HI) begin
            clu_hi[15:8] = b;
        end else if (rec_pos == C_POS_CLU_LO_LO) begin
            clu_lo[7:0] = b;
        end else if (rec_pos == C_POS_CLU_LO_HI) begin
            clu_lo[15:8] = b;
        end else if (rec_pos >= C_POS_SIZE_FIRST && rec_pos <= C_POS_SIZE_LAST) begin
            size_lo[8*(rec_pos - C_POS_SIZE_FIRST) +: 8] = b;
        end else if (rec_pos == C_POS_REC_LAST && !drop_rec) begin
            got = 1'b1;
            entry.base_name     = base_acc;
            entry.base_length   = base_len;
            entry.ext_name      = ext_acc;
            entry.ext_length    = ext_len;
            entry.is_directory  = attr_byte[C_ATTR_DIR_BIT];
            entry.file_bytes    = {b, size_lo};
            entry.start_cluster = {clu_hi, clu_lo};
        end
        rec_pos = rec_pos + 5'd1;
    endtask

    // Mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] rand_char();
        case ($urandom_range(0, 4))
            0:       return 8'($urandom_range(C_CHAR_UPPER_A, C_CHAR_UPPER_Z));
            1:       return 8'($urandom_range(CH_LOWER_A, CH_LOWER_Z));
            2:       return 8'($urandom_range(CH_DIGIT_0, CH_DIGIT_9));
            3:       return 8'($urandom_range(8'h80, 8'hFF));
            default: return 8'($urandom);
        endcase
    endfunction

    // Name byte at index idx of a field whose text ends after len characters
    function automatic logic [7:0] name_char(input int idx, input int len);
        logic [7:0] c;
        if (idx < len) begin
            c = rand_char();
            if (c == C_CHAR_SPACE) c = C_CHAR_UPPER_A;
            return c;
        end
        if (idx == len) return C_CHAR_SPACE;
        // trailing junk after the terminating space must be ignored
        return ($urandom_range(0, 3) == 0) ? rand_char() : C_CHAR_SPACE;
    endfunction

    // Build one 32-byte record, byte i in bits 8i+7..8i
    function automatic logic [255:0] mk_rec(input logic [87:0] name, input logic [7:0] attr,
                                            input logic [31:0] cluster, input logic [31:0] size,
                                            input logic [7:0] fill);
        logic [255:0] r;
        for (int i = 0; i < 32; i++) r[8*i +: 8] = fill;
        for (int i = 0; i < 11; i++) r[8*i +: 8] = name[87-8*i -: 8];
        r[8*C_POS_ATTR +: 8]      = attr;
        r[8*C_POS_CLU_HI_LO +: 16] = cluster[31:16];
        r[8*C_POS_CLU_LO_LO +: 16] = cluster[15:0];
        r[8*C_POS_SIZE_FIRST +: 32] = size;
        return r;
    endfunction

    // Mostly well-formed entries with random content, then skip marks and noise
    function automatic logic [255:0] rand_record();
        logic [255:0] r;
        int style;
        int base_n;
        int ext_n;
        for (int i = 0; i < 8; i++) r[32*i +: 32] = $urandom;
        style = $urandom_range(0, 9);
        if (style < 7) begin
            base_n = $urandom_range(0, 8);
            ext_n  = $urandom_range(0, 3);
            for (int i = 0; i < 8; i++) r[8*i +: 8] = name_char(i, base_n);
            for (int i = 0; i < 3; i++) r[8*(C_POS_EXT_FIRST + i) +: 8] = name_char(i, ext_n);
            case ($urandom_range(0, 3))
                0:       r[8*C_POS_ATTR +: 8] = ATTR_DIRECTORY;
                1:       r[8*C_POS_ATTR +: 8] = ATTR_ARCHIVE;
                2:       r[8*C_POS_ATTR +: 8] = ATTR_NONE;
                default: ;
            endcase
        end else if (style < 9) begin
            case ($urandom_range(0, 3))
                0:       r[7:0] = C_MARK_FREE;
                1:       r[7:0] = C_MARK_DELETED;
                2:       r[7:0] = C_CHAR_DOT;
                default: r[8*C_POS_ATTR +: 8] = C_ATTR_LONG_NAME;
            endcase
        end
        return r;
    endfunction

    // Offer one byte, hold it until taken, then update the expectation
    task automatic push_byte(input logic [7:0] b, input bit quiet, input bit is_last);
        int gap;
        bit got;
        t_result entry;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_dir_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        bytes_sent++;
        parse_dir_byte(b, got, entry);
        if (is_last) begin
            if (!got) records_skipped++;
            case (cur_kind)
                ROW_PREDICT: if (got) pending_entries.push_back(entry);
                ROW_TYPED:   pending_entries.push_back(cur_typed);
                default:     ;
            endcase
        end
    endtask

    task automatic send_record(input logic [255:0] raw, input bit quiet);
        for (int i = 0; i < 32; i++) push_byte(raw[8*i +: 8], quiet, i == 31);
        records_sent++;
    endtask

    task automatic add_row(input logic [255:0] raw, input t_row_kind kind, input t_result e);
        t_dir_row row;
        row.raw   = raw;
        row.kind  = kind;
        row.entry = e;
        dir_rows.push_back(row);
    endtask

    task automatic show_entry(input string tag, input t_result e);
        $display("  %s base=%h/%0d ext=%h/%0d dir=%b size=%h cluster=%h", tag,
                 e.base_name, e.base_length, e.ext_name, e.ext_length,
                 e.is_directory, e.file_bytes, e.start_cluster);
    endtask

    // Result side: random stalls, one long hold-off on request
    initial begin
        int gap;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                i_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                long_hold_req = 1'b0;
            end else if ($urandom_range(0, 9) == 0) begin
                i_stall <= 1'b0;
                repeat (80) @(posedge i_clk);
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    i_stall <= 1'b1;
                    repeat (gap) @(posedge i_clk);
                end
                i_stall <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    end

    // Check each result transaction, then run the watchdog
    always @(posedge i_clk) begin
        t_result seen_entry;
        t_result want_entry;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                seen_entry = {o_base_name, o_base_length, o_ext_name, o_ext_length,
                              o_is_directory, o_file_bytes, o_start_cluster};
                if (pending_entries.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("tb: entry with nothing expected");
                        show_entry("actual  ", seen_entry);
                    end
                end else begin
                    want_entry = pending_entries.pop_front();
                    entries_checked++;
                    if (seen_entry !== want_entry) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS) begin
                            $display("tb: mismatch on entry %0d", entries_checked);
                            show_entry("expected", want_entry);
                            show_entry("actual  ", seen_entry);
                        end
                    end
                end
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    // Stimulus: directed table, then random records
    initial begin
        t_result e;

        // empty base name in a directory entry: only the directory bit is set
        e = '0;
        e.is_directory = 1'b1;
        add_row(mk_rec("           ", ATTR_DIRECTORY, 32'h0, 32'h0, 8'h00), ROW_TYPED, e);
        // every byte 0xFF: full-length names of high bytes, all fields at maximum
        e = '1;
        e.base_length = C_BASE_MAX;
        e.ext_length  = C_EXT_MAX;
        add_row({256{1'b1}}, ROW_TYPED, e);
        // free, deleted, dot and long-name records give nothing
        e = '0;
        add_row(mk_rec({C_MARK_FREE, "REE    TXT"}, ATTR_ARCHIVE, 32'h1234_5678,
                       32'h9ABC_DEF0, 8'h3C), ROW_NONE, e);
        add_row(mk_rec({C_MARK_DELETED, "ELETED TXT"}, ATTR_ARCHIVE, 32'hFFFF_FFFF,
                       32'h0000_0001, 8'hC3), ROW_NONE, e);
        add_row(mk_rec(".          ", ATTR_DIRECTORY, 32'h0000_0002, 32'h0, 8'h00),
                ROW_NONE, e);
        add_row(mk_rec("ABCDEFGHIJK", C_ATTR_LONG_NAME, 32'h0, 32'hFFFF_FFFF, 8'hFF),
                ROW_NONE, e);
        // ordinary and boundary names, checked by the tracked parser
        add_row(mk_rec("README  TXT", ATTR_ARCHIVE, 32'h0001_0002, 32'h0000_1234, 8'h5A),
                ROW_PREDICT, e);
        add_row(mk_rec("AZ@[az{~A.B", 8'h01, 32'h8000_0001, 32'h8000_0000, 8'hC3),
                ROW_PREDICT, e);
        add_row(mk_rec("AB CDEFGX Y", 8'h1F, 32'h00FF_FF00, 32'hFF00_00FF, 8'h96),
                ROW_PREDICT, e);
        add_row(mk_rec({8'h01, "          "}, ATTR_NONE, 32'h0, 32'h0, 8'h00),
                ROW_PREDICT, e);
        add_row(mk_rec("FOO        ", 8'h0E, 32'hFFFF_0000, 32'h0000_FFFF, 8'hFF),
                ROW_PREDICT, e);
        add_row(mk_rec({8'hE4, "ABCDEFG.XY"}, ATTR_DIRECTORY, 32'h0102_0304,
                       32'h0506_0708, 8'h69), ROW_PREDICT, e);
        add_row(mk_rec({8'hE6, 8'h2F, 8'h2D, "12345", " 9Z"}, 8'hEF, 32'h7FFF_7FFF,
                       32'h7FFF_FFFF, 8'h81), ROW_PREDICT, e);
        add_row(mk_rec({"X", 8'h80, 8'h7F, 8'hDA, 8'hC1, "   ", "  Q"}, 8'hF0,
                       32'hA5A5_5A5A, 32'h5A5A_A5A5, 8'h42), ROW_PREDICT, e);

        // hold reset, then release it on a clock edge
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            cur_kind  = dir_rows[k].kind;
            cur_typed = dir_rows[k].entry;
            send_record(dir_rows[k].raw, 1'b0);
        end

        // random records; the result side holds off for a long stretch early on
        cur_kind = ROW_PREDICT;
        long_hold_req = 1'b1;
        for (int n = 0; n < NUM_RANDOM_RECORDS; n++) begin
            send_record(rand_record(), $urandom_range(0, 3) == 0);
        end
        i_valid <= 1'b0;

        // drain outstanding entries
        while (pending_entries.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("tb: %0d directory records (%0d bytes) streamed, %0d skipped by marks",
                 records_sent, bytes_sent, records_skipped);
        $display("tb: %0d parsed entries compared, %0d mismatches", entries_checked,
                 mismatch_count);
        if (mismatch_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
